### hw/rtl/kfsp_pkg.sv
// ============================================================================
// Keyframe sequence player package
// Shared sizes, storage types, command, mode, phase and status codes.
// ============================================================================
package kfsp_pkg;

  // Table size and image width.
  localparam int MAX_KEYS   = 256;
  localparam int IMAGE_BITS = 8;

  // Table index width and count width (the count must be able to hold MAX_KEYS).
  localparam int KEY_IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);

  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  typedef logic [KEY_IDX_W-1:0]  key_idx_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [IMAGE_BITS-1:0] img_t;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

  // Play modes; any other code behaves as swing.
  localparam logic [1:0] MODE_ONCE = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;

  // Playback phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PENDING = 4'b0010,
    PH_FWD     = 4'b0100,
    PH_BACK    = 4'b1000
  } phase_e;

  // Status codes shown on the result.
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_FWD     = 2'd2;
  localparam logic [1:0] ST_BACK    = 2'd3;

endpackage

### hw/rtl/kfsp_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
module kfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read at the written address returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/keyframe_sequence_player_core.sv
// ============================================================================
// Keyframe sequence player core
// Plays a table of (time, image) keyframes once, looping, or swinging.
// ============================================================================
// An accepted request's result appears in the output register in the next cycle.
// Throughput: one request per cycle while the output register drains; the key
// tables are read ahead at the next-state position, so a tick needs
// only the registered read data already waiting at the RAM outputs.
// Reset: phase idle, position and start stamp zero, play mode and frame count zero.
// The key tables are not cleared; entries hold unknown data until written.
module keyframe_sequence_player_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [31:0]                     now_ms_i,
  input  logic [7:0]                      key_index_i,
  input  logic [31:0]                     key_time_ms_i,
  input  logic [7:0]                      key_image_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            show_valid_o,
  output logic [7:0]                      image_number_o,
  output logic [1:0]                      play_status_o,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kfsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kfsp_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [1:0]                     play_mode_q, play_mode_d;
  logic [kfsp_pkg::CFG_DAT_W-1:0] frame_count_q, frame_count_d;

  // Playback state.
  kfsp_pkg::phase_e phase_q, phase_d;
  kfsp_pkg::count_t pos_q, pos_d;
  kfsp_pkg::time_t  stamp_q, stamp_d;

  // Effective frame counts (current and next).
  kfsp_pkg::count_t n_q, n_d;

  // Table access.
  logic                 tbl_we;
  kfsp_pkg::key_idx_t   tbl_waddr;
  kfsp_pkg::key_idx_t   slot_raddr, last_raddr;
  logic [kfsp_pkg::TIME_W+kfsp_pkg::IMAGE_BITS-1:0] slot_wdata, slot_rdata;
  kfsp_pkg::time_t      slot_time_ram, last_time_ram, slot_time, last_time;
  kfsp_pkg::img_t       slot_img_ram, slot_img;
  logic                 slot_byp_q, last_byp_q;
  kfsp_pkg::time_t      wtime_q;
  kfsp_pkg::img_t       wimg_q;

  // Tick evaluation.
  logic             in_accept;
  kfsp_pkg::phase_e ph_t;
  kfsp_pkg::time_t  stamp_t, delta, key_t;
  kfsp_pkg::count_t len, pos_inc;
  logic             hit, do_end, show;

  // Output register.
  logic       out_valid_q;
  logic       show_q;
  logic [7:0] image_q;
  logic [1:0] status_q, status_d;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_comb begin
    play_mode_d   = play_mode_q;
    frame_count_d = frame_count_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        kfsp_pkg::CFG_PLAY_MODE:   play_mode_d   = cfg_data_i[1:0];
        kfsp_pkg::CFG_FRAME_COUNT: frame_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame count clamped to the table size.
  assign n_q = (32'(frame_count_q) > 32'(kfsp_pkg::MAX_KEYS)) ?
               kfsp_pkg::count_t'(kfsp_pkg::MAX_KEYS) : kfsp_pkg::count_t'(frame_count_q);
  assign n_d = (32'(frame_count_d) > 32'(kfsp_pkg::MAX_KEYS)) ?
               kfsp_pkg::count_t'(kfsp_pkg::MAX_KEYS) : kfsp_pkg::count_t'(frame_count_d);

  // Table write from a write request inside the table range.
  assign tbl_we    = in_accept && (cmd_i == kfsp_pkg::CMD_WRITE) &&
                     (32'(key_index_i) < 32'(kfsp_pkg::MAX_KEYS));
  assign tbl_waddr = kfsp_pkg::key_idx_t'(key_index_i);

  // Read addresses come from the next state, so data is ready for the next tick.
  assign slot_raddr = (phase_d == kfsp_pkg::PH_BACK) ?
                      kfsp_pkg::key_idx_t'(n_d - kfsp_pkg::count_t'(1) - pos_d) :
                      kfsp_pkg::key_idx_t'(pos_d);
  assign last_raddr = kfsp_pkg::key_idx_t'(n_d - kfsp_pkg::count_t'(1));

  // Slot memory holds image and time side by side; a second copy of the times
  // serves the last-key read.
  assign slot_wdata = {kfsp_pkg::img_t'(key_image_i), key_time_ms_i};

  kfsp_ram #(
    .WIDTH (kfsp_pkg::TIME_W + kfsp_pkg::IMAGE_BITS),
    .DEPTH (kfsp_pkg::MAX_KEYS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  kfsp_ram #(.WIDTH(kfsp_pkg::TIME_W), .DEPTH(kfsp_pkg::MAX_KEYS)) u_time_last_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (key_time_ms_i),
    .raddr_i (last_raddr),
    .rdata_o (last_time_ram)
  );

  assign slot_time_ram = slot_rdata[kfsp_pkg::TIME_W-1:0];
  assign slot_img_ram  = slot_rdata[kfsp_pkg::TIME_W +: kfsp_pkg::IMAGE_BITS];

  // Forward data written in the same cycle as the read of that entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_byp_q <= 1'b0;
      last_byp_q <= 1'b0;
    end else begin
      slot_byp_q <= tbl_we && (tbl_waddr == slot_raddr);
      last_byp_q <= tbl_we && (tbl_waddr == last_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    wtime_q <= key_time_ms_i;
    wimg_q  <= kfsp_pkg::img_t'(key_image_i);
  end

  assign slot_time = slot_byp_q ? wtime_q : slot_time_ram;
  assign slot_img  = slot_byp_q ? wimg_q  : slot_img_ram;
  assign last_time = last_byp_q ? wtime_q : last_time_ram;

  // Tick evaluation terms: a pending phase latches the stamp and runs forward.
  assign ph_t    = (phase_q == kfsp_pkg::PH_PENDING) ? kfsp_pkg::PH_FWD : phase_q;
  assign stamp_t = (phase_q == kfsp_pkg::PH_PENDING) ? now_ms_i : stamp_q;
  assign delta   = now_ms_i - stamp_t;
  assign len     = (ph_t == kfsp_pkg::PH_BACK) ? (n_q - kfsp_pkg::count_t'(1)) : n_q;
  assign key_t   = (ph_t == kfsp_pkg::PH_BACK) ? (last_time - slot_time) : slot_time;
  assign hit     = delta > key_t;
  assign pos_inc = pos_q + kfsp_pkg::count_t'(1);

  // Next playback state.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    stamp_d = stamp_q;
    show    = 1'b0;
    do_end  = 1'b0;
    if (in_accept) begin
      case (cmd_i)
        kfsp_pkg::CMD_TICK: begin
          if (phase_q != kfsp_pkg::PH_IDLE) begin
            phase_d = ph_t;
            stamp_d = stamp_t;
            if (n_q == '0) begin
              // Frames removed while playing.
              phase_d = kfsp_pkg::PH_IDLE;
              pos_d   = '0;
            end else if ((ph_t == kfsp_pkg::PH_BACK) && (len == '0)) begin
              // Empty backward list turns forward without a show.
              phase_d = kfsp_pkg::PH_FWD;
              pos_d   = '0;
              stamp_d = now_ms_i;
            end else if (pos_q >= len) begin
              do_end = 1'b1;
            end else if (hit) begin
              show  = 1'b1;
              pos_d = pos_inc;
              if (pos_inc == len) begin
                do_end = 1'b1;
              end
            end
          end
        end
        kfsp_pkg::CMD_START: begin
          if (n_q != '0) begin
            phase_d = kfsp_pkg::PH_PENDING;
            pos_d   = '0;
          end
        end
        default: ;
      endcase

      // End of list: stop, restart in place, or reverse direction.
      if (do_end) begin
        pos_d = '0;
        if (play_mode_q == kfsp_pkg::MODE_ONCE) begin
          phase_d = kfsp_pkg::PH_IDLE;
        end else begin
          stamp_d = now_ms_i;
          if (play_mode_q != kfsp_pkg::MODE_LOOP) begin
            if ((ph_t == kfsp_pkg::PH_FWD) && (n_q > kfsp_pkg::count_t'(1))) begin
              phase_d = kfsp_pkg::PH_BACK;
            end else begin
              phase_d = kfsp_pkg::PH_FWD;
            end
          end
        end
      end
    end
  end

  // Phase to status code.
  always_comb begin
    case (phase_d)
      kfsp_pkg::PH_IDLE:    status_d = kfsp_pkg::ST_IDLE;
      kfsp_pkg::PH_PENDING: status_d = kfsp_pkg::ST_PENDING;
      kfsp_pkg::PH_FWD:     status_d = kfsp_pkg::ST_FWD;
      kfsp_pkg::PH_BACK:    status_d = kfsp_pkg::ST_BACK;
      default:              status_d = kfsp_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_mode_q   <= '0;
      frame_count_q <= '0;
      phase_q       <= kfsp_pkg::PH_IDLE;
      pos_q         <= '0;
      stamp_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      play_mode_q   <= play_mode_d;
      frame_count_q <= frame_count_d;
      phase_q       <= phase_d;
      pos_q         <= pos_d;
      stamp_q       <= stamp_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      show_q   <= show;
      image_q  <= show ? 8'(slot_img) : 8'd0;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign show_valid_o   = show_q;
  assign image_number_o = image_q;
  assign play_status_o  = status_q;

endmodule

### hw/rtl/kfsp_checker.sv
// ============================================================================
// Keyframe sequence player checker
// Port-level properties of the player core, bound to the top level.
// ============================================================================
module kfsp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic                            show_valid_o,
  input  logic [7:0]                      image_number_o,
  input  logic [1:0]                      play_status_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(show_valid_o) &&
      $stable(image_number_o) && $stable(play_status_o))
    else $error("stalled result changed");

  // Every accepted request yields a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // Only a tick request can show an image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i != kfsp_pkg::CMD_TICK) |=> !show_valid_o)
    else $error("non-tick request showed an image");

  // An empty output register never holds off requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with output register empty");

  // A result without a show carries image zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !show_valid_o |-> image_number_o == 8'd0)
    else $error("image number set without a show");

endmodule

bind keyframe_sequence_player_core kfsp_checker u_kfsp_checker (.*);
